// ===== sv/rfb_pkg.sv =====
// Shared constants, tables and helpers for the radial falloff bend deformer.
package rfb_pkg;

  // Default number of fraction bits in every coordinate and register
  localparam int FRAC_BITS_DEF = 16;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENVELOPE = 2'd0;
  localparam logic [1:0] CFG_DROPOFF  = 2'd1;
  localparam logic [1:0] CFG_BEND     = 2'd2;

  // Quadrant codes of the phase
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Radians to turns, Q32, and one turn in radians, Q30
  localparam logic [29:0]        INV_TWO_PI_Q32 = 30'd683565276;
  localparam logic signed [33:0] TWO_PI_Q30     = 34'sd6746518852;

  // One in Q1.30
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // Reciprocals ceil(2^38/den) of the Taylor denominators, exact for n < 2^30
  localparam int RECIP_SH = 38;
  localparam logic [37:0] SIN_RECIP [5] = '{
    38'd2498890064,   // 110
    38'd3817748708,   // 72
    38'd6544712071,   // 42
    38'd13743895348,  // 20
    38'd45812984491   // 6
  };
  localparam logic [37:0] COS_RECIP [6] = '{
    38'd2082408386,   // 132
    38'd3054198967,   // 90
    38'd4908534053,   // 56
    38'd9162596899,   // 30
    38'd22906492246,  // 12
    38'd137438953472  // 2
  };

  // Saturation to the 32-bit signed range from a wide signed value
  localparam int SAT_W = 80;
  localparam logic signed [SAT_W-1:0] SAT_HI = 80'sd2147483647;
  localparam logic signed [SAT_W-1:0] SAT_LO = -80'sd2147483648;

  function automatic logic [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic [31:0] res;
    if (v > SAT_HI) begin
      res = 32'h7FFF_FFFF;
    end else if (v < SAT_LO) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ===== sv/radial_falloff_bend_deformer_top.sv =====
// Top level of the radial falloff bend deformer: a fully pipelined vertex bender.
//
//   channel | direction | ports                                   | handshake
//   --------+-----------+-----------------------------------------+-------------------
//   in      | input     | in_pos_x, in_pos_z                      | in_valid/in_ready
//   out     | output    | out_bent_x, out_bent_z                  | out_valid/out_ready
//   cfg     | input     | cfg_index, cfg_data                     | cfg_valid/cfg_ready
//
// One word enters per cycle unless the stages hold. The path runs through the bit-per-stage
// falloff divider (FRAC_BITS stages) and the bit-per-stage bend radius divider
// (2*FRAC_BITS+1 stages), with the sin/cos polynomial alongside.
// A two-entry output buffer takes results, so input is still accepted while one waits.
// All stages hold together only when that buffer is full and out_ready is low.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults.
module radial_falloff_bend_deformer_top #(
  parameter int FRAC_BITS = rfb_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_bent_x,
  output logic signed [31:0] out_bent_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int FB  = FRAC_BITS;
  localparam int S_F = FB + 5;              // bend factor stage
  localparam int S_R = 3 * FB + 8;          // bend radius stage
  localparam int S_P = S_R + 1;             // final product stage
  localparam int QW  = 2 * FB + 1;          // radius quotient width
  localparam int RW  = 63 - FB;             // clamped radius width
  localparam int CW  = (2 * FB + 2 > RW) ? 2 * FB + 2 : RW;
  localparam int AW  = FB + 32;             // angle bits that reach the phase
  localparam int HL  = (AW + 1) / 2;
  localparam int HW  = AW - HL;
  localparam int NRD = 2 * FB - 15;         // sin/cos wait for the radius
  localparam int DW  = RW + 1;
  localparam int PW  = DW + FB + 2;
  localparam int SW  = rfb_pkg::SAT_W;
  localparam logic signed [CW-1:0] RAD_MAX = CW'(64'sd1 <<< (61 - FB));
  localparam logic signed [CW-1:0] RAD_MIN = -RAD_MAX;

  // Configuration registers
  logic signed [31:0] env_r, drop_r, mag_r;
  logic [63:0]        dr2_r;

  // Pipeline control
  logic             adv;
  logic [S_P:0]     v_r;
  logic signed [31:0] x_r [0:S_P];
  logic signed [31:0] z_r [0:S_P];
  logic             byp_r [S_F:S_P];

  // Falloff path
  logic [63:0]        sqx_r, sqz_r, rem1_r;
  logic [63:0]        frem_r [0:FB-1];
  logic [FB-1:0]      fq_r   [0:FB-1];
  logic [FB-1:0]      w_r;
  logic signed [31:0] pct_r;
  logic signed [63:0] mgp_r;
  logic signed [31:0] f_r;

  // Radius divider
  logic [31:0]            dv_rem_r [0:2*FB];
  logic [QW-1:0]          dv_q_r   [0:2*FB];
  logic [31:0]            dv_d_r   [0:2*FB];
  logic                   dv_neg_r [0:2*FB];
  logic signed [QW:0]     rq_r;
  logic signed [RW-1:0]   rad_r, radp_r;

  // Angle path
  logic [AW-1:0]        a_r;
  logic [AW-1:0]        pp0_r;
  logic [HW-1:0]        pp1_r;
  logic [1:0]           quad_r, q4_r;
  logic signed [29:0]   r_r;
  logic signed [30:0]   th_r;
  logic signed [30:0]   hth_r [0:10];
  logic [29:0]          hh2_r [0:10];
  logic [1:0]           hq_r  [0:12];
  logic [29:0]          sin_n_r [0:4];
  logic [30:0]          sin_t_r [0:4];
  logic [29:0]          cos_n_r [0:5];
  logic [30:0]          cos_t_r [0:5];
  logic signed [FB+1:0] s_r, s2_r, sr_r, cr_r;
  logic signed [FB+1:0] rs_r [0:NRD-1];
  logic signed [FB+1:0] rc_r [0:NRD-1];
  logic signed [PW-1:0] pz_r, px_r;

  // Output buffer
  logic [31:0] fifo_x_r [2];
  logic [31:0] fifo_z_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push, pop;

  // Handshakes
  assign adv       = (cnt_r != 2'd2) || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r  <= 32'(5) << FB;
      drop_r <= 32'(1) << FB;
      mag_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rfb_pkg::CFG_ENVELOPE: env_r  <= cfg_data;
        rfb_pkg::CFG_DROPOFF:  drop_r <= cfg_data;
        rfb_pkg::CFG_BEND:     mag_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Square the dropoff radius
  logic [63:0] dr2_nxt;
  assign dr2_nxt = 64'(drop_r[30:0]) * 64'(drop_r[30:0]);
  always_ff @(posedge clk) begin
    dr2_r <= dr2_nxt;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[S_P-1:0], in_valid};
    end
  end

  // Carry the point along
  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0] <= in_pos_x;
      z_r[0] <= in_pos_z;
      for (int k = 1; k <= S_P; k++) begin
        x_r[k] <= x_r[k-1];
        z_r[k] <= z_r[k-1];
      end
    end
  end

  // Squares of the coordinate magnitudes
  logic [31:0] mx, mz;
  logic [63:0] sqx_nxt, sqz_nxt, d_sum, rem1_nxt;
  assign mx      = in_pos_x[31] ? 32'd0 - in_pos_x : in_pos_x;
  assign mz      = in_pos_z[31] ? 32'd0 - in_pos_z : in_pos_z;
  assign sqx_nxt = 64'(mx) * 64'(mz - mz + mx);
  assign sqz_nxt = 64'(mz) * 64'(mz);
  assign d_sum   = sqx_r + sqz_r;
  // Outside the dropoff the quotient is zero, which zeroes the falloff
  assign rem1_nxt = (d_sum >= dr2_r) ? 64'd0 : dr2_r - d_sum;

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r  <= sqx_nxt;
      sqz_r  <= sqz_nxt;
      rem1_r <= rem1_nxt;
    end
  end

  // Restoring division (dr2 - d) / dr2, one quotient bit per stage
  for (genvar gk = 0; gk < FB; gk++) begin : g_fdiv
    logic [63:0]   rem_in, tv, rem_nxt;
    logic [FB-1:0] q_in, q_nxt;
    logic          ge;
    if (gk == 0) begin : g_first
      assign rem_in = rem1_r;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = frem_r[gk-1];
      assign q_in   = fq_r[gk-1];
    end
    assign tv      = {rem_in[62:0], 1'b0};
    assign ge      = tv >= dr2_r;
    assign rem_nxt = ge ? tv - dr2_r : tv;
    assign q_nxt   = {q_in[FB-2:0], ge};
    always_ff @(posedge clk) begin
      if (adv) begin
        frem_r[gk] <= rem_nxt;
        fq_r[gk]   <= q_nxt;
      end
    end
  end

  // Weight, falloff, bend factor
  logic [2*FB-1:0]    qsq;
  logic signed [FB+32:0] pctp;
  logic signed [31:0] pct_nxt;
  logic signed [63:0] mgp_nxt, fsh;
  logic signed [31:0] f_nxt;
  logic               byp_nxt;
  assign qsq     = fq_r[FB-1] * fq_r[FB-1];
  assign pctp    = env_r * $signed({1'b0, w_r});
  assign pct_nxt = drop_r[31] ? env_r : pctp[FB+31:FB];
  assign mgp_nxt = mag_r * pct_r;
  assign fsh     = mgp_r >>> FB;
  assign f_nxt   = rfb_pkg::sat32(SW'(fsh));
  assign byp_nxt = (env_r == 32'sd0) || (drop_r == 32'sd0) || (f_nxt == 32'sd0);

  // Register weight, falloff and bend factor; advance the bypass flag with the point
  always_ff @(posedge clk) begin
    if (adv) begin
      w_r        <= qsq[2*FB-1:FB];
      pct_r      <= pct_nxt;
      mgp_r      <= mgp_nxt;
      f_r        <= f_nxt;
      byp_r[S_F] <= byp_nxt;
      for (int k = S_F + 1; k <= S_P; k++) begin
        byp_r[k] <= byp_r[k-1];
      end
    end
  end

  // Radius 2^(2*FB) / |f|, one quotient bit per stage
  for (genvar gk = 0; gk <= 2 * FB; gk++) begin : g_rdiv
    logic [31:0]   d_in, rem_in, rem_nxt;
    logic [QW-1:0] q_in, q_nxt;
    logic          n_in, ge;
    logic [32:0]   tv;
    if (gk == 0) begin : g_first
      assign d_in   = f_r[31] ? 32'd0 - f_r : f_r;
      assign rem_in = '0;
      assign q_in   = '0;
      assign n_in   = f_r[31];
    end else begin : g_next
      assign d_in   = dv_d_r[gk-1];
      assign rem_in = dv_rem_r[gk-1];
      assign q_in   = dv_q_r[gk-1];
      assign n_in   = dv_neg_r[gk-1];
    end
    assign tv      = {rem_in, 1'(gk == 0)};
    assign ge      = tv >= {1'b0, d_in};
    assign rem_nxt = ge ? 32'(tv - {1'b0, d_in}) : tv[31:0];
    assign q_nxt   = {q_in[QW-2:0], ge};
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[gk] <= rem_nxt;
        dv_q_r[gk]   <= q_nxt;
        dv_d_r[gk]   <= d_in;
        dv_neg_r[gk] <= n_in;
      end
    end
  end

  // Sign and clamp the radius
  logic signed [QW:0]   rq_nxt;
  logic signed [CW-1:0] rqx, radc;
  assign rq_nxt = dv_neg_r[2*FB] ? -$signed({1'b0, dv_q_r[2*FB]})
                                 : $signed({1'b0, dv_q_r[2*FB]});
  assign rqx    = CW'(rq_r);
  assign radc   = (rqx > RAD_MAX) ? RAD_MAX : ((rqx < RAD_MIN) ? RAD_MIN : rqx);

  always_ff @(posedge clk) begin
    if (adv) begin
      rq_r  <= rq_nxt;
      rad_r <= RW'(radc);
    end
  end

  // Angle z*f, then its phase in turns
  logic signed [63:0]        zf;
  logic signed [2*FB+31:0]   zfx;
  logic [HL+29:0]            pp0_nxt;
  logic [HW+29:0]            pp1_nxt;
  logic [AW-1:0]             ph_sum;
  logic [31:0]               ph_u;
  logic signed [63:0]        thp;
  logic signed [61:0]        thsq;
  assign zf      = z_r[S_F] * f_r;
  assign zfx     = (2 * FB + 32)'(zf);
  assign pp0_nxt = a_r[HL-1:0] * rfb_pkg::INV_TWO_PI_Q32;
  assign pp1_nxt = a_r[AW-1:HL] * rfb_pkg::INV_TWO_PI_Q32;
  assign ph_sum  = pp0_r + {pp1_r, {HL{1'b0}}};
  assign ph_u    = ph_sum[AW-1:FB] + 32'h2000_0000;
  assign thp     = r_r * rfb_pkg::TWO_PI_Q30;
  assign thsq    = th_r * th_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r      <= zfx[2*FB+31:FB];
      pp0_r    <= pp0_nxt[AW-1:0];
      pp1_r    <= pp1_nxt[HW-1:0];
      quad_r   <= ph_u[31:30];
      r_r      <= $signed({~ph_u[29], ph_u[28:0]});
      th_r     <= thp[62:32];
      q4_r     <= quad_r;
      hth_r[0] <= th_r;
      hh2_r[0] <= thsq[59:30];
      hq_r[0]  <= q4_r;
      for (int k = 1; k <= 10; k++) begin
        hth_r[k] <= hth_r[k-1];
        hh2_r[k] <= hh2_r[k-1];
      end
      for (int k = 1; k <= 12; k++) begin
        hq_r[k] <= hq_r[k-1];
      end
    end
  end

  // Sine polynomial, two stages per Horner step
  for (genvar gi = 0; gi < 5; gi++) begin : g_sin
    logic [30:0] t_in;
    logic [60:0] hp;
    logic [67:0] mp;
    if (gi == 0) begin : g_first
      assign t_in = rfb_pkg::Q30_ONE;
    end else begin : g_next
      assign t_in = sin_t_r[gi-1];
    end
    assign hp = hh2_r[2*gi] * t_in;
    assign mp = sin_n_r[gi] * rfb_pkg::SIN_RECIP[gi];
    always_ff @(posedge clk) begin
      if (adv) begin
        sin_n_r[gi] <= hp[59:30];
        sin_t_r[gi] <= rfb_pkg::Q30_ONE - {1'b0, mp[67:rfb_pkg::RECIP_SH]};
      end
    end
  end

  // Cosine polynomial, two stages per Horner step
  for (genvar gi = 0; gi < 6; gi++) begin : g_cos
    logic [30:0] t_in;
    logic [60:0] hp;
    logic [67:0] mp;
    if (gi == 0) begin : g_first
      assign t_in = rfb_pkg::Q30_ONE;
    end else begin : g_next
      assign t_in = cos_t_r[gi-1];
    end
    assign hp = hh2_r[2*gi] * t_in;
    assign mp = cos_n_r[gi] * rfb_pkg::COS_RECIP[gi];
    always_ff @(posedge clk) begin
      if (adv) begin
        cos_n_r[gi] <= hp[59:30];
        cos_t_r[gi] <= rfb_pkg::Q30_ONE - {1'b0, mp[67:rfb_pkg::RECIP_SH]};
      end
    end
  end

  // Scale sine by theta, rotate both by the quadrant
  logic signed [62:0]   sp;
  logic [30:0]          cvs;
  logic signed [FB+1:0] c_w, sr_nxt, cr_nxt;
  assign sp  = hth_r[10] * $signed({1'b0, sin_t_r[4]});
  assign cvs = cos_t_r[5] >> (30 - FB);
  assign c_w = $signed(cvs[FB+1:0]);

  always_comb begin
    case (hq_r[12])
      rfb_pkg::QUAD_0: begin
        sr_nxt = s2_r;
        cr_nxt = c_w;
      end
      rfb_pkg::QUAD_1: begin
        sr_nxt = c_w;
        cr_nxt = -s2_r;
      end
      rfb_pkg::QUAD_2: begin
        sr_nxt = -s2_r;
        cr_nxt = -c_w;
      end
      rfb_pkg::QUAD_3: begin
        sr_nxt = -c_w;
        cr_nxt = s2_r;
      end
      default: begin
        sr_nxt = s2_r;
        cr_nxt = c_w;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r      <= sp[61:60-FB];
      s2_r     <= s_r;
      sr_r     <= sr_nxt;
      cr_r     <= cr_nxt;
      rs_r[0]  <= sr_r;
      rc_r[0]  <= cr_r;
      for (int k = 1; k < NRD; k++) begin
        rs_r[k] <= rs_r[k-1];
        rc_r[k] <= rc_r[k-1];
      end
    end
  end

  // Bend products about the radius
  logic signed [DW-1:0] dz, dx;
  logic signed [PW-1:0] pz_nxt, px_nxt;
  assign dz     = DW'(rad_r) - DW'(x_r[S_R]);
  assign dx     = DW'(x_r[S_R]) - DW'(rad_r);
  assign pz_nxt = rs_r[NRD-1] * dz;
  assign px_nxt = rc_r[NRD-1] * dx;

  always_ff @(posedge clk) begin
    if (adv) begin
      pz_r   <= pz_nxt;
      px_r   <= px_nxt;
      radp_r <= rad_r;
    end
  end

  // Shift, offset, saturate, or pass the point through
  logic signed [PW:0] rxs;
  logic [31:0]        res_x, res_z;
  assign rxs   = (PW + 1)'(px_r >>> FB) + (PW + 1)'(radp_r);
  assign res_z = byp_r[S_P] ? z_r[S_P] : rfb_pkg::sat32(SW'(pz_r >>> FB));
  assign res_x = byp_r[S_P] ? x_r[S_P] : rfb_pkg::sat32(SW'(rxs));

  // Output buffer, two words deep
  assign push      = adv && v_r[S_P];
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_bent_x = fifo_x_r[rd_ptr_r];
  assign out_bent_z = fifo_z_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_x_r[wr_ptr_r] <= res_x;
      fifo_z_r[wr_ptr_r] <= res_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule
